>>> rtl/sle_pkg.sv
// shared types, character codes and helpers for the serial line editor
`timescale 1ns / 1ps

package sle_pkg;

	localparam int STORE_DEPTH = 128;
	localparam int ERASE_W     = 7;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_ETB = 8'h17;
	localparam logic [7:0] CH_NAK = 8'h15;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	localparam logic ACT_RECV = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	typedef enum logic [2:0] {
		KIND_ECHO    = 3'd0,
		KIND_CRLF    = 3'd1,
		KIND_BELL    = 3'd2,
		KIND_ERASE   = 3'd3,
		KIND_DELIVER = 3'd4,
		KIND_EMPTY   = 3'd5,
		KIND_BUSY    = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRD,
		ST_WCHK,
		ST_POP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       action;
		logic [7:0] in_char;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         out_char;
		logic [ERASE_W-1:0] erase_count;
		logic               line_end;
	} out_item_t;

	// space, tab, lf, vt, ff, cr
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || (c inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

>>> rtl/serial_line_editor.sv
// serial line editor top level: line store, edit sequencer and result register
//
//  channel | direction | payload                               | handshake
//  --------+-----------+---------------------------------------+------------------
//  in      | to block  | in_item_t  (action, in_char)          | in_valid / in_stall
//  out     | from block| out_item_t (kind, out_char, erase_count, line_end) | out_valid / out_stall
//
// most items go from acceptance straight to the load of the result register; a pop first
// waits for the line store read. ctrl-w walks back through the store, reading and then
// blank-testing each removed character in turn.
// reset clears pointers, count and mode; the store itself is not cleared.
// in_stall is high from the cycle after a transfer until the result has been handed to
// the output register, which holds while out_stall is high.
`timescale 1ns / 1ps

module serial_line_editor #(
	parameter int STORE_DEPTH = sle_pkg::STORE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sle_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sle_pkg::out_item_t  out_data
);

	localparam int PTR_W = $clog2(STORE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(STORE_DEPTH - 1);
	localparam logic [PTR_W-1:0] FULL_CNT = PTR_W'(STORE_DEPTH - 2);
	localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W+1)'(STORE_DEPTH);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? LAST_IDX : p - PTR_W'(1);
	endfunction

	sle_pkg::state_t    state_q, state_d;
	logic [PTR_W-1:0]   rp_q, rp_d;
	logic [PTR_W-1:0]   wp_q, wp_d;
	logic [PTR_W-1:0]   cnt_q, cnt_d;
	logic               ready_q, ready_d;
	sle_pkg::out_item_t res_q, res_d;
	logic               out_valid_q, out_valid_d;
	sle_pkg::out_item_t out_data_q, out_data_d;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [7:0]         ram_wdata;
	logic [PTR_W-1:0]   ram_raddr;
	logic [7:0]         ram_rdata;

	logic [PTR_W:0]     back_sum;
	logic [PTR_W-1:0]   wp_back;
	logic [7:0]         c;

	sle_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign c = in_data.in_char;

	// write pointer after ctrl-u: back by the whole count around the ring
	assign back_sum = {1'b0, wp_q} + DEPTH_X - {1'b0, cnt_q};
	assign wp_back  = (back_sum >= DEPTH_X) ? PTR_W'(back_sum - DEPTH_X) : PTR_W'(back_sum);

	always_comb begin
		state_d     = state_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		cnt_d       = cnt_q;
		ready_d     = ready_q;
		res_d       = res_q;
		out_valid_d = out_valid_q && out_stall;
		out_data_d  = out_data_q;
		ram_we      = 1'b0;
		ram_waddr   = wp_q;
		ram_wdata   = c;
		ram_raddr   = ptr_prev(wp_q);

		case (state_q)
			sle_pkg::ST_IDLE: begin
				if (in_valid) begin
					res_d.kind        = sle_pkg::KIND_EMPTY;
					res_d.out_char    = '0;
					res_d.erase_count = '0;
					res_d.line_end    = 1'b0;
					state_d           = sle_pkg::ST_OUT;
					if (in_data.action == sle_pkg::ACT_POP) begin
						if (ready_q && cnt_q != '0) begin
							ram_raddr = rp_q;
							state_d   = sle_pkg::ST_POP;
						end else begin
							ready_d = 1'b0;
						end
					end else if (ready_q) begin
						res_d.kind = sle_pkg::KIND_BUSY;
					end else if (c == sle_pkg::CH_CR) begin
						ram_we     = 1'b1;
						ram_wdata  = sle_pkg::CH_LF;
						wp_d       = ptr_next(wp_q);
						cnt_d      = cnt_q + PTR_W'(1);
						ready_d    = 1'b1;
						res_d.kind = sle_pkg::KIND_CRLF;
					end else if (c == sle_pkg::CH_BS || c == sle_pkg::CH_DEL) begin
						if (cnt_q == '0) begin
							res_d.kind = sle_pkg::KIND_BELL;
						end else begin
							wp_d              = ptr_prev(wp_q);
							cnt_d             = cnt_q - PTR_W'(1);
							res_d.kind        = sle_pkg::KIND_ERASE;
							res_d.erase_count = sle_pkg::ERASE_W'(1);
						end
					end else if (c == sle_pkg::CH_ETB) begin
						res_d.kind = sle_pkg::KIND_ERASE;
						// store read of the char before the cursor is already issued
						if (cnt_q != '0) begin
							state_d = sle_pkg::ST_WCHK;
						end
					end else if (c == sle_pkg::CH_NAK) begin
						wp_d              = wp_back;
						cnt_d             = '0;
						res_d.kind        = sle_pkg::KIND_ERASE;
						res_d.erase_count = sle_pkg::ERASE_W'(cnt_q);
					end else if (cnt_q >= FULL_CNT) begin
						res_d.kind = sle_pkg::KIND_BELL;
					end else begin
						ram_we         = 1'b1;
						wp_d           = ptr_next(wp_q);
						cnt_d          = cnt_q + PTR_W'(1);
						res_d.kind     = sle_pkg::KIND_ECHO;
						res_d.out_char = c;
					end
				end
			end
			sle_pkg::ST_WRD: begin
				state_d = sle_pkg::ST_WCHK;
			end
			sle_pkg::ST_WCHK: begin
				if (sle_pkg::is_blank(ram_rdata)) begin
					state_d = sle_pkg::ST_OUT;
				end else begin
					wp_d              = ptr_prev(wp_q);
					cnt_d             = cnt_q - PTR_W'(1);
					res_d.erase_count = res_q.erase_count + sle_pkg::ERASE_W'(1);
					state_d = (cnt_q == PTR_W'(1)) ? sle_pkg::ST_OUT : sle_pkg::ST_WRD;
				end
			end
			sle_pkg::ST_POP: begin
				res_d.kind     = sle_pkg::KIND_DELIVER;
				res_d.out_char = ram_rdata;
				rp_d           = ptr_next(rp_q);
				cnt_d          = cnt_q - PTR_W'(1);
				if (cnt_q == PTR_W'(1)) begin
					res_d.line_end = 1'b1;
					ready_d        = 1'b0;
				end
				state_d = sle_pkg::ST_OUT;
			end
			sle_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					out_data_d  = res_q;
					state_d     = sle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sle_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sle_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			wp_q        <= '0;
			cnt_q       <= '0;
			ready_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rp_q        <= rp_d;
			wp_q        <= wp_d;
			cnt_q       <= cnt_d;
			ready_q     <= ready_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q      <= res_d;
		out_data_q <= out_data_d;
	end

	assign in_stall  = (state_q != sle_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> rtl/sle_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sle_pkg::STORE_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/sle_checker.sv
// port-level checks for the serial line editor, bound to the top level
`timescale 1ns / 1ps

module sle_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input sle_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// one item in flight: busy right after each input transfer
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	a_count_only_erase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != sle_pkg::KIND_ERASE |-> out_data.erase_count == '0)
		else $error("erase count on a non-erase result");

	a_end_only_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != sle_pkg::KIND_DELIVER |-> !out_data.line_end)
		else $error("line end on a non-delivery result");

	a_char_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != sle_pkg::KIND_ECHO
			&& out_data.kind != sle_pkg::KIND_DELIVER |-> out_data.out_char == '0)
		else $error("character on a result that carries none");

endmodule

bind serial_line_editor sle_checker u_sle_checker (.*);
